// ===== sv/deq_pkg.sv =====
// Shared types and operation/status codes for the double-ended queue.
package deq_pkg;

    typedef logic [2:0]         t_func;
    typedef logic [1:0]         t_status;
    typedef logic signed [31:0] t_word;

    localparam int WORD_W = 32;

    localparam t_func FUNC_PUSH_FRONT = 3'd0;
    localparam t_func FUNC_PUSH_BACK  = 3'd1;
    localparam t_func FUNC_POP_FRONT  = 3'd2;
    localparam t_func FUNC_POP_BACK   = 3'd3;
    localparam t_func FUNC_SHOW       = 3'd4;
    localparam t_func FUNC_CLEAR      = 3'd5;

    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_EMPTY = 2'd1;
    localparam t_status ST_FULL  = 2'd2;

endpackage

// ===== sv/deq_if.sv =====
// Command and response channel interfaces of the double-ended queue.
interface deq_cmd_if;
    logic            valid;
    logic            ready;
    deq_pkg::t_func  func;
    deq_pkg::t_word  value;

    modport source (output valid, output func, output value, input ready);
    modport sink   (input valid, input func, input value, output ready);
endinterface

interface deq_rsp_if;
    logic             valid;
    logic             ready;
    deq_pkg::t_word   item;
    deq_pkg::t_status status;
    logic             last;

    modport source (output valid, output item, output status, output last, input ready);
    modport sink   (input valid, input item, input status, input last, output ready);
endinterface

// ===== sv/double_ended_queue_core.sv =====
// Double-ended queue core: ring store in RAM with front index and entry count.
//
// Usage:
//   i_cmd carries one word per operation (func, value). o_rsp returns result
//   words (item, status, last); last marks the final result of a command.
//   Push and clear answer from the command itself: the result is in the
//   output register in the cycle after acceptance, and a new command may
//   follow in the next cycle if the receiver takes the result.
//   Pop reads the entry RAM, whose read data is registered: the word passes
//   through S_POP into the output register, and no command is taken meanwhile.
//   Show streams the live entries front to back, one per cycle from the RAM
//   read port while the receiver takes them; an empty queue gives one report.
//   Unused func codes are accepted and produce no result.
//   A command is accepted only while no multi-cycle command is in flight and
//   the output register is empty or being taken in the same cycle.
//   When the receiver stalls, the output register holds its word and the
//   RAM read data holds as well, so a stalled show resumes where it stopped.
//   Reset clears the state, the front index, the count and the output valid; the RAM is
//   not cleared since an entry is read only after it was written.
module double_ended_queue_core #(
    parameter int CAPACITY = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    deq_cmd_if.sink   i_cmd,
    deq_rsp_if.source o_rsp
);
    import deq_pkg::*;

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int SW = CW + 1;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_POP  = 2'd1;
    localparam logic [1:0] S_SHOW = 2'd2;

    // Wrap front + offset into the ring; the sum stays below twice the capacity.
    function automatic logic [IW-1:0] ring(input logic [IW-1:0] base,
                                           input logic [CW-1:0] off);
        logic [SW-1:0] sum;
        sum = SW'(base) + SW'(off);
        if (sum >= SW'(CAPACITY)) begin
            sum = sum - SW'(CAPACITY);
        end
        return sum[IW-1:0];
    endfunction

    logic [1:0]    r_state, n_state;
    logic [IW-1:0] r_front, n_front;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_off,   n_off;
    logic          r_ov,    n_ov;
    t_word         r_item,  n_item;
    t_status       r_status, n_status;
    logic          r_last,  n_last;

    logic              out_free;
    logic              accept;
    logic              is_full;
    logic              is_empty;
    logic              show_last;
    logic              ram_we;
    logic [IW-1:0]     ram_waddr;
    logic              ram_re;
    logic [IW-1:0]     ram_raddr;
    logic [WORD_W-1:0] ram_rdata;

    deq_ram #(
        .WIDTH (WORD_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_cmd.value),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // The output register can take a word when empty or drained this cycle.
    assign out_free    = !r_ov || o_rsp.ready;
    assign i_cmd.ready = (r_state == S_IDLE) && out_free;
    assign accept      = i_cmd.valid && i_cmd.ready;
    assign is_full     = (r_count == CW'(CAPACITY));
    assign is_empty    = (r_count == '0);
    assign show_last   = ((r_off + CW'(1)) == r_count);

    always_comb begin
        n_state   = r_state;
        n_front   = r_front;
        n_count   = r_count;
        n_off     = r_off;
        n_ov      = r_ov && !o_rsp.ready;
        n_item    = r_item;
        n_status  = r_status;
        n_last    = r_last;
        ram_we    = 1'b0;
        ram_waddr = r_front;
        ram_re    = 1'b0;
        ram_raddr = r_front;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (i_cmd.func) inside
                        FUNC_PUSH_FRONT, FUNC_PUSH_BACK: begin
                            n_ov   = 1'b1;
                            n_last = 1'b1;
                            if (is_full) begin
                                // Drop the value, leave the queue alone.
                                n_item   = '0;
                                n_status = ST_FULL;
                            end else begin
                                n_item   = i_cmd.value;
                                n_status = ST_OK;
                                ram_we   = 1'b1;
                                n_count  = r_count + CW'(1);
                                if (i_cmd.func == FUNC_PUSH_FRONT) begin
                                    n_front   = ring(r_front, CW'(CAPACITY - 1));
                                    ram_waddr = n_front;
                                end else begin
                                    ram_waddr = ring(r_front, r_count);
                                end
                            end
                        end
                        FUNC_POP_FRONT, FUNC_POP_BACK: begin
                            if (is_empty) begin
                                n_ov     = 1'b1;
                                n_item   = '0;
                                n_status = ST_EMPTY;
                                n_last   = 1'b1;
                            end else begin
                                // Issue the read now; S_POP delivers the word once the output register is free.
                                ram_re  = 1'b1;
                                n_count = r_count - CW'(1);
                                n_state = S_POP;
                                if (i_cmd.func == FUNC_POP_FRONT) begin
                                    ram_raddr = r_front;
                                    n_front   = ring(r_front, CW'(1));
                                end else begin
                                    ram_raddr = ring(r_front, r_count - CW'(1));
                                end
                            end
                        end
                        FUNC_SHOW: begin
                            if (is_empty) begin
                                n_ov     = 1'b1;
                                n_item   = '0;
                                n_status = ST_EMPTY;
                                n_last   = 1'b1;
                            end else begin
                                ram_re    = 1'b1;
                                ram_raddr = r_front;
                                n_off     = '0;
                                n_state   = S_SHOW;
                            end
                        end
                        FUNC_CLEAR: begin
                            n_count  = '0;
                            n_front  = '0;
                            n_ov     = 1'b1;
                            n_item   = '0;
                            n_status = ST_OK;
                            n_last   = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_POP: begin
                // Hold the read data until the output register frees up.
                if (out_free) begin
                    n_ov     = 1'b1;
                    n_item   = ram_rdata;
                    n_status = ST_OK;
                    n_last   = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            S_SHOW: begin
                // Move one entry out and fetch the next in the same cycle.
                if (out_free) begin
                    n_ov     = 1'b1;
                    n_item   = ram_rdata;
                    n_status = ST_OK;
                    n_last   = show_last;
                    if (show_last) begin
                        n_state = S_IDLE;
                    end else begin
                        ram_re    = 1'b1;
                        ram_raddr = ring(r_front, r_off + CW'(1));
                        n_off     = r_off + CW'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_front <= '0;
            r_count <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_front <= n_front;
            r_count <= n_count;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_off    <= n_off;
        r_item   <= n_item;
        r_status <= n_status;
        r_last   <= n_last;
    end

    assign o_rsp.valid  = r_ov;
    assign o_rsp.item   = r_item;
    assign o_rsp.status = r_status;
    assign o_rsp.last   = r_last;
endmodule

// ===== sv/deq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== sv/deq_checker.sv =====
// Port-level assertions for the double-ended queue core, bound to the core module.
module deq_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_cmd_valid,
    input logic             i_cmd_ready,
    input deq_pkg::t_func   i_cmd_func,
    input deq_pkg::t_word   i_cmd_value,
    input logic             i_rsp_valid,
    input logic             i_rsp_ready,
    input deq_pkg::t_word   i_rsp_item,
    input deq_pkg::t_status i_rsp_status,
    input logic             i_rsp_last
);
    import deq_pkg::*;

    logic cmd_acc;
    assign cmd_acc = i_cmd_valid && i_cmd_ready;

    // A stalled response word holds.
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_item)
            && $stable(i_rsp_status) && $stable(i_rsp_last))
        else $error("response word changed while stalled");

    // Empty and full reports always close their command and carry a zero item.
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_status != ST_OK |-> i_rsp_last && i_rsp_item == '0)
        else $error("error report not a single zero last word");

    // A push answers next cycle with its value echoed or a full report.
    a_push_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_acc && (i_cmd_func == FUNC_PUSH_FRONT || i_cmd_func == FUNC_PUSH_BACK)
        |=> i_rsp_valid && i_rsp_last
            && (i_rsp_status == ST_FULL
                || (i_rsp_status == ST_OK && i_rsp_item == $past(i_cmd_value))))
        else $error("push acknowledgement wrong");

    // A clear answers next cycle with a zero ok acknowledgement.
    a_clear_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_acc && i_cmd_func == FUNC_CLEAR
        |=> i_rsp_valid && i_rsp_last && i_rsp_status == ST_OK && i_rsp_item == '0)
        else $error("clear acknowledgement wrong");

    // Reset drops any pending response.
    a_rst_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("response valid after reset");
endmodule

bind double_ended_queue_core deq_checker u_deq_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_cmd_valid  (i_cmd.valid),
    .i_cmd_ready  (i_cmd.ready),
    .i_cmd_func   (i_cmd.func),
    .i_cmd_value  (i_cmd.value),
    .i_rsp_valid  (o_rsp.valid),
    .i_rsp_ready  (o_rsp.ready),
    .i_rsp_item   (o_rsp.item),
    .i_rsp_status (o_rsp.status),
    .i_rsp_last   (o_rsp.last)
);

// ===== tb/tb.sv =====
// Self-checking testbench for double_ended_queue_core: mirror model, stimulus and checks.
module tb;
    import deq_pkg::*;

    localparam int DEPTH       = 16;
    localparam int RANDOM_OPS  = 420;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int DRAIN_WAIT  = 40;

    // Codes the block accepts and ignores.
    localparam t_func FUNC_SPARE_A = 3'd6;
    localparam t_func FUNC_SPARE_B = 3'd7;

    typedef struct packed {
        t_word   item;
        t_status status;
        logic    last;
    } t_result;

    typedef enum int {PH_FILL, PH_DRAIN, PH_MIXED} t_phase;

    // Mirror of the queue: tracks ring contents and queues the result words
    // that each accepted command should produce.
    class deque_mirror;
        t_word   ring [DEPTH];
        int      front_pos;
        int      live_count;
        t_result expected_words [$];
        int      error_count;

        function void add_result(t_word item, t_status status, logic last);
            t_result r;
            r.item   = item;
            r.status = status;
            r.last   = last;
            expected_words.push_back(r);
        endfunction

        function void note_command(t_func func, t_word value);
            int slot;
            case (func)
                FUNC_PUSH_FRONT, FUNC_PUSH_BACK: begin
                    if (live_count >= DEPTH) begin
                        add_result('0, ST_FULL, 1'b1);
                    end else begin
                        if (func == FUNC_PUSH_FRONT) begin
                            front_pos = (front_pos + DEPTH - 1) % DEPTH;
                            slot = front_pos;
                        end else begin
                            slot = (front_pos + live_count) % DEPTH;
                        end
                        ring[slot] = value;
                        live_count++;
                        add_result(value, ST_OK, 1'b1);
                    end
                end
                FUNC_POP_FRONT, FUNC_POP_BACK: begin
                    if (live_count == 0) begin
                        add_result('0, ST_EMPTY, 1'b1);
                    end else begin
                        if (func == FUNC_POP_FRONT) begin
                            slot = front_pos;
                            front_pos = (front_pos + 1) % DEPTH;
                        end else begin
                            slot = (front_pos + live_count - 1) % DEPTH;
                        end
                        live_count--;
                        add_result(ring[slot], ST_OK, 1'b1);
                    end
                end
                FUNC_SHOW: begin
                    if (live_count == 0) begin
                        add_result('0, ST_EMPTY, 1'b1);
                    end else begin
                        for (int i = 0; i < live_count; i++) begin
                            add_result(ring[(front_pos + i) % DEPTH], ST_OK,
                                       (i == live_count - 1));
                        end
                    end
                end
                FUNC_CLEAR: begin
                    live_count = 0;
                    front_pos  = 0;
                    add_result('0, ST_OK, 1'b1);
                end
                default: ;
            endcase
        endfunction

        function void check_result(t_word item, t_status status, logic last);
            t_result exp_word;
            if (expected_words.size() == 0) begin
                $error("unexpected result word: item %0d status %0d last %0d",
                       item, status, last);
                error_count++;
                return;
            end
            exp_word = expected_words.pop_front();
            if (item !== exp_word.item) begin
                $error("item: expected %0d, got %0d", exp_word.item, item);
                error_count++;
            end
            if (status !== exp_word.status) begin
                $error("status: expected %0d, got %0d", exp_word.status, status);
                error_count++;
            end
            if (last !== exp_word.last) begin
                $error("last: expected %0d, got %0d", exp_word.last, last);
                error_count++;
            end
        endfunction

        function int pending();
            return expected_words.size();
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    deq_cmd_if cmd_bus ();
    deq_rsp_if rsp_bus ();

    deque_mirror mirror;

    double_ended_queue_core #(
        .CAPACITY(DEPTH)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_bus),
        .o_rsp   (rsp_bus)
    );

    always #5 i_clk = ~i_clk;

    // Mostly back-to-back, sometimes a short pause, rarely a long one.
    function automatic int gap_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 25);
    endfunction

    // Favor the boundary values now and then; otherwise any 32-bit pattern.
    function automatic t_word pick_value();
        case ($urandom_range(0, 31))
            0:       return 32'h7fff_ffff;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return 32'hffff_ffff;
            default: return t_word'($urandom);
        endcase
    endfunction

    // Weight the operation mix by phase so the queue swings between full and empty.
    function automatic t_func pick_func(t_phase phase);
        int r;
        int push_lim;
        int pop_lim;
        r = $urandom_range(0, 99);
        case (phase)
            PH_FILL:  begin push_lim = 70; pop_lim = 82; end
            PH_DRAIN: begin push_lim = 20; pop_lim = 80; end
            default:  begin push_lim = 40; pop_lim = 75; end
        endcase
        if (r < push_lim)
            return ($urandom_range(0, 1) != 0) ? FUNC_PUSH_FRONT : FUNC_PUSH_BACK;
        if (r < pop_lim)
            return ($urandom_range(0, 1) != 0) ? FUNC_POP_FRONT : FUNC_POP_BACK;
        if (r < 93) return FUNC_SHOW;
        if (r < 97) return ($urandom_range(0, 1) != 0) ? FUNC_SPARE_A : FUNC_SPARE_B;
        return FUNC_CLEAR;
    endfunction

    // Present one command word, hold it until taken, then idle for gap cycles.
    // Entered and left just after a falling edge.
    task automatic send_word(input t_func func, input t_word value, input int gap);
        cmd_bus.valid <= 1'b1;
        cmd_bus.func  <= func;
        cmd_bus.value <= value;
        do @(posedge i_clk); while (!cmd_bus.ready);
        mirror.note_command(func, value);
        @(negedge i_clk);
        if (gap > 0) begin
            cmd_bus.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    // Receiver: mix calm stretches, long stalls and bursty ready.
    initial begin
        int   run;
        logic level;
        rsp_bus.ready = 1'b0;
        forever begin
            case ($urandom_range(0, 9))
                0, 1: begin run = $urandom_range(30, 60); level = 1'b1; end
                2:    begin run = $urandom_range(10, 30); level = 1'b0; end
                default: begin
                    run   = $urandom_range(1, 3);
                    level = $urandom_range(0, 1);
                end
            endcase
            repeat (run) begin
                @(negedge i_clk);
                rsp_bus.ready <= level;
            end
        end
    end

    // Check every accepted result word against the mirror.
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_bus.valid && rsp_bus.ready)
            mirror.check_result(rsp_bus.item, rsp_bus.status, rsp_bus.last);
    end

    // Watchdog: end the run if it hangs.
    initial begin
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("** double_ended_queue_core: FAILED **");
        $finish;
    end

    initial begin
        t_phase phase;
        t_func  func;
        int     sent;
        int     span;
        bit     calm;

        mirror        = new;
        i_rst_n       = 1'b0;
        cmd_bus.valid = 1'b0;
        cmd_bus.func  = FUNC_PUSH_FRONT;
        cmd_bus.value = '0;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: empty cases, extremes, ignored codes, fill to full and overflow, show, clear.
        send_word(FUNC_POP_FRONT, '0, 0);
        send_word(FUNC_POP_BACK, '0, 1);
        send_word(FUNC_SHOW, '0, 0);
        send_word(FUNC_PUSH_FRONT, 32'h7fff_ffff, 0);
        send_word(FUNC_PUSH_BACK, 32'h8000_0000, 0);
        send_word(FUNC_POP_FRONT, '0, 0);
        send_word(FUNC_POP_BACK, '0, 2);
        send_word(FUNC_SPARE_A, 32'hffff_ffff, 0);
        send_word(FUNC_SPARE_B, 32'h5555_5555, 0);
        for (int i = 0; i < DEPTH; i++)
            send_word((i % 2 == 0) ? FUNC_PUSH_FRONT : FUNC_PUSH_BACK,
                      (i % 2 == 0) ? t_word'(32'h1 << (2 * i)) : t_word'(~(32'h1 << i)), 0);
        send_word(FUNC_PUSH_FRONT, 32'h1234_5678, 0);
        send_word(FUNC_PUSH_BACK, 32'h8765_4321, 0);
        send_word(FUNC_SHOW, '0, 0);
        send_word(FUNC_CLEAR, '0, 0);
        send_word(FUNC_SHOW, '0, 3);

        // Random: phases of fill, drain or mixed traffic; some phases run without gaps.
        sent = 0;
        while (sent < RANDOM_OPS) begin
            phase = t_phase'($urandom_range(0, 2));
            calm  = ($urandom_range(0, 3) == 0);
            span  = $urandom_range(10, 40);
            for (int k = 0; k < span && sent < RANDOM_OPS; k++) begin
                func = pick_func(phase);
                send_word(func, pick_value(), calm ? 0 : gap_cycles());
                sent++;
            end
        end
        cmd_bus.valid <= 1'b0;

        // Drain outstanding results, then watch for strays.
        while (mirror.pending() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (mirror.error_count == 0)
            $display("** double_ended_queue_core: PASSED **");
        else
            $display("** double_ended_queue_core: FAILED **");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/deq_pkg.sv
sv/deq_if.sv
sv/deq_ram.sv
sv/double_ended_queue_core.sv
sv/deq_checker.sv
tb/tb.sv
